/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// Each expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_RUN(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed while running");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

/* hw/rtl/spcp_pkg.sv */
// Shared types, constants and helpers for the servo pulse command parser.
// No dependencies.
`timescale 1ns / 1ps

package spcp_pkg;

  localparam int PULSE_W = 15;
  localparam int ACC_W   = 16;
  localparam int CHAR_W  = 8;

  localparam logic [PULSE_W-1:0] PULSE_RESET    = 15'd1551;
  localparam logic [PULSE_W-1:0] PAN_MIN_RESET  = 15'd1500;
  localparam logic [PULSE_W-1:0] PAN_MAX_RESET  = 15'd2300;
  localparam logic [PULSE_W-1:0] TILT_MIN_RESET = 15'd1200;
  localparam logic [PULSE_W-1:0] TILT_MAX_RESET = 15'd1900;

  localparam logic [ACC_W-1:0] ACC_LIMIT = 16'hFFFF;

  localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT0 = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT9 = 8'h39;

  localparam logic [1:0] TOKENS_MAX = 2'd3;
  localparam logic [1:0] TOKEN_PAN  = 2'd1;
  localparam logic [1:0] TOKEN_TILT = 2'd2;

  typedef enum logic [1:0] {
    CFG_PAN_MIN  = 2'd0,
    CFG_PAN_MAX  = 2'd1,
    CFG_TILT_MIN = 2'd2,
    CFG_TILT_MAX = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pan_min;
    logic [PULSE_W-1:0] pan_max;
    logic [PULSE_W-1:0] tilt_min;
    logic [PULSE_W-1:0] tilt_max;
  } limits_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_byte;
    logic              line_end;
  } char_beat_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pan_pulse;
    logic [PULSE_W-1:0] tilt_pulse;
    logic               applied;
  } result_t;

  // acc * 10 + digit, clamped at ACC_LIMIT
  function automatic logic [ACC_W-1:0] acc_step(input logic [ACC_W-1:0] acc,
                                                input logic [3:0] digit);
    logic [ACC_W+3:0] prod;
    prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{ACC_W{1'b0}}, digit};
    acc_step = (prod > {4'b0000, ACC_LIMIT}) ? ACC_LIMIT : prod[ACC_W-1:0];
  endfunction

endpackage

/* hw/rtl/servo_pulse_command_parser_top.sv */
// Servo pulse command parser. Takes one character beat per cycle; each beat
// is registered, then parsed against the per-line state in the next cycle.
// A beat marked line_end yields one result beat (pan and tilt pulse widths
// plus an applied flag), loaded into the result register. Sustained rate is
// one character per cycle; input stalls only while a line-end beat is held
// and the result register still holds an untaken beat. Configuration is
// always ready and should be written only while the block is idle.
// Depends on spcp_pkg, spcp_cfg_regs, spcp_in_reg, spcp_parser, spcp_out_reg.
`timescale 1ns / 1ps

module servo_pulse_command_parser_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [spcp_pkg::CHAR_W-1:0]  in_char_byte,
  input  logic                         in_line_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [spcp_pkg::PULSE_W-1:0] out_pan_pulse,
  output logic [spcp_pkg::PULSE_W-1:0] out_tilt_pulse,
  output logic                         out_applied,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [spcp_pkg::PULSE_W-1:0] cfg_data
);

  spcp_pkg::limits_t    limits;
  spcp_pkg::char_beat_t in_beat, hold_beat;
  spcp_pkg::result_t    res, out_res;
  logic                 hold_valid, advance, out_free, res_valid;

  assign in_beat.char_byte = in_char_byte;
  assign in_beat.line_end  = in_line_end;

  // a held line-end beat needs room in the result register
  assign advance = hold_valid && (!hold_beat.line_end || out_free);

  spcp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  spcp_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_beat    (in_beat),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_beat  (hold_beat),
    .in_ready   (in_ready)
  );

  spcp_parser u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .beat      (hold_beat),
    .limits    (limits),
    .res_valid (res_valid),
    .res       (res)
  );

  spcp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_pan_pulse  = out_res.pan_pulse;
  assign out_tilt_pulse = out_res.tilt_pulse;
  assign out_applied    = out_res.applied;

endmodule

/* hw/rtl/spcp_cfg_regs.sv */
// Range limit registers written over the configuration channel.
// Depends on spcp_pkg.
`timescale 1ns / 1ps

module spcp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [spcp_pkg::PULSE_W-1:0]  cfg_data,
  output spcp_pkg::limits_t             limits
);

  spcp_pkg::limits_t lim_r, lim_nxt;

  assign cfg_ready = 1'b1;
  assign limits    = lim_r;

  always_comb begin
    lim_nxt = lim_r;
    if (cfg_valid) begin
      case (spcp_pkg::cfg_idx_t'(cfg_index))
        spcp_pkg::CFG_PAN_MIN:  lim_nxt.pan_min  = cfg_data;
        spcp_pkg::CFG_PAN_MAX:  lim_nxt.pan_max  = cfg_data;
        spcp_pkg::CFG_TILT_MIN: lim_nxt.tilt_min = cfg_data;
        spcp_pkg::CFG_TILT_MAX: lim_nxt.tilt_max = cfg_data;
        default:                lim_nxt = lim_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.pan_min  <= spcp_pkg::PAN_MIN_RESET;
      lim_r.pan_max  <= spcp_pkg::PAN_MAX_RESET;
      lim_r.tilt_min <= spcp_pkg::TILT_MIN_RESET;
      lim_r.tilt_max <= spcp_pkg::TILT_MAX_RESET;
    end else begin
      lim_r <= lim_nxt;
    end
  end

endmodule

/* hw/rtl/spcp_in_reg.sv */
// Input register for character beats.
// Depends on spcp_pkg.
`timescale 1ns / 1ps

module spcp_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  spcp_pkg::char_beat_t in_beat,
  input  logic                 advance,
  output logic                 hold_valid,
  output spcp_pkg::char_beat_t hold_beat,
  output logic                 in_ready
);

  logic                 valid_r, valid_nxt;
  spcp_pkg::char_beat_t beat_r;

  // Free when empty or when the held beat moves on this cycle.
  assign in_ready   = !valid_r || advance;
  assign hold_valid = valid_r;
  assign hold_beat  = beat_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat_r <= in_beat;
    end
  end

endmodule

/* hw/rtl/spcp_parser.sv */
// Per-line tokenizer state, pulse width registers and line judgement.
// Depends on spcp_pkg.
`timescale 1ns / 1ps

module spcp_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  spcp_pkg::char_beat_t beat,
  input  spcp_pkg::limits_t    limits,
  output logic                 res_valid,
  output spcp_pkg::result_t    res
);

  logic [spcp_pkg::PULSE_W-1:0] pan_r, pan_nxt, tilt_r, tilt_nxt;
  logic [spcp_pkg::ACC_W-1:0]   acc1_r, acc1_nxt, acc2_r, acc2_nxt;
  logic                         num1_r, num1_nxt, num2_r, num2_nxt;
  logic [1:0]                   count_r, count_nxt;
  logic                         inside_r, inside_nxt;
  logic                         ended_r, ended_nxt;
  logic                         is_digit;
  logic [3:0]                   digit;
  logic                         ok;
  logic [spcp_pkg::CHAR_W-1:0]  diff;

  assign diff     = beat.char_byte - spcp_pkg::CHAR_DIGIT0;
  assign digit    = diff[3:0];
  assign is_digit = beat.char_byte inside {[spcp_pkg::CHAR_DIGIT0 : spcp_pkg::CHAR_DIGIT9]};

  // Character step
  always_comb begin
    acc1_nxt   = acc1_r;
    acc2_nxt   = acc2_r;
    num1_nxt   = num1_r;
    num2_nxt   = num2_r;
    count_nxt  = count_r;
    inside_nxt = inside_r;
    ended_nxt  = ended_r;
    if (!ended_r) begin
      if (beat.char_byte == spcp_pkg::CHAR_NUL) begin
        ended_nxt  = 1'b1;
        inside_nxt = 1'b0;
      end else if (beat.char_byte == spcp_pkg::CHAR_COMMA) begin
        inside_nxt = 1'b0;
      end else begin
        if (!inside_r) begin
          inside_nxt = 1'b1;
          if (count_r != spcp_pkg::TOKENS_MAX) begin
            count_nxt = count_r + 2'd1;
          end
        end
        if (count_nxt == spcp_pkg::TOKEN_PAN) begin
          if (is_digit) acc1_nxt = spcp_pkg::acc_step(acc1_r, digit);
          else          num1_nxt = 1'b0;
        end else if (count_nxt == spcp_pkg::TOKEN_TILT) begin
          if (is_digit) acc2_nxt = spcp_pkg::acc_step(acc2_r, digit);
          else          num2_nxt = 1'b0;
        end
      end
    end
  end

  // Judgement on the state after the last character
  always_comb begin
    ok = (count_nxt >= spcp_pkg::TOKEN_TILT) && num1_nxt && num2_nxt &&
         (acc1_nxt >= {1'b0, limits.pan_min})  && (acc1_nxt <= {1'b0, limits.pan_max}) &&
         (acc2_nxt >= {1'b0, limits.tilt_min}) && (acc2_nxt <= {1'b0, limits.tilt_max});
    pan_nxt  = pan_r;
    tilt_nxt = tilt_r;
    if (fire && beat.line_end && ok) begin
      pan_nxt  = acc1_nxt[spcp_pkg::PULSE_W-1:0];
      tilt_nxt = acc2_nxt[spcp_pkg::PULSE_W-1:0];
    end
  end

  assign res_valid      = fire && beat.line_end;
  assign res.pan_pulse  = pan_nxt;
  assign res.tilt_pulse = tilt_nxt;
  assign res.applied    = ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_r    <= spcp_pkg::PULSE_RESET;
      tilt_r   <= spcp_pkg::PULSE_RESET;
      acc1_r   <= '0;
      acc2_r   <= '0;
      num1_r   <= 1'b1;
      num2_r   <= 1'b1;
      count_r  <= '0;
      inside_r <= 1'b0;
      ended_r  <= 1'b0;
    end else begin
      pan_r  <= pan_nxt;
      tilt_r <= tilt_nxt;
      if (fire) begin
        if (beat.line_end) begin
          // line judged: back to a fresh line
          acc1_r   <= '0;
          acc2_r   <= '0;
          num1_r   <= 1'b1;
          num2_r   <= 1'b1;
          count_r  <= '0;
          inside_r <= 1'b0;
          ended_r  <= 1'b0;
        end else begin
          acc1_r   <= acc1_nxt;
          acc2_r   <= acc2_nxt;
          num1_r   <= num1_nxt;
          num2_r   <= num2_nxt;
          count_r  <= count_nxt;
          inside_r <= inside_nxt;
          ended_r  <= ended_nxt;
        end
      end
    end
  end

endmodule

/* hw/rtl/spcp_out_reg.sv */
// Result register on the output channel.
// Depends on spcp_pkg.
`timescale 1ns / 1ps

module spcp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  spcp_pkg::result_t res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output spcp_pkg::result_t out_res
);

  logic              valid_r, valid_nxt;
  spcp_pkg::result_t res_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (free) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= res;
    end
  end

endmodule

/* hw/rtl/spcp_port_checker.sv */
// Port-level checks for the servo pulse command parser, bound to the top.
// Depends on spcp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spcp_port_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [spcp_pkg::PULSE_W-1:0] out_pan_pulse,
  input logic [spcp_pkg::PULSE_W-1:0] out_tilt_pulse,
  input logic                         out_applied
);

  logic [spcp_pkg::PULSE_W-1:0] last_pan_r, last_tilt_r;
  logic                         out_beat;
  logic [2*spcp_pkg::PULSE_W:0] out_word;
  logic                         keeps_last;

  assign out_beat   = out_valid && out_ready;
  assign out_word   = {out_pan_pulse, out_tilt_pulse, out_applied};
  assign keeps_last = (out_pan_pulse == last_pan_r) && (out_tilt_pulse == last_tilt_r);

  // pulse widths last delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pan_r  <= spcp_pkg::PULSE_RESET;
      last_tilt_r <= spcp_pkg::PULSE_RESET;
    end else if (out_beat) begin
      last_pan_r  <= out_pan_pulse;
      last_tilt_r <= out_tilt_pulse;
    end
  end

  `ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid)
  `ASSERT_RUN(a_out_holds, out_valid && !out_ready |=> out_valid && $stable(out_word))
  `ASSERT_RUN(a_stall_only_on_full_out, !in_ready |-> out_valid && !out_ready)
  `ASSERT_RUN(a_rejected_keeps_pulses, out_beat && !out_applied |-> keeps_last)

endmodule

bind servo_pulse_command_parser_top spcp_port_checker u_port_chk (.*);
